FILE: src/ets_pkg.sv
package ets_pkg;

  parameter int TABLE_DEPTH_DEF = 16;

  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
  localparam logic [10:0] MAX_FRAME = 11'd1514;

  typedef struct packed {
    logic        mode;
    logic [47:0] dest_mac;
    logic [15:0] ethertype;
    logic [10:0] frame_length;
  } in_item_t;

  typedef struct packed {
    logic        entry_valid;
    logic [15:0] entry_type;
    logic [31:0] entry_frames;
    logic [39:0] entry_bytes;
    logic [31:0] for_me_frames;
    logic [31:0] multicast_frames;
    logic [39:0] ipv4_bytes;
    logic [39:0] ipv6_bytes;
    logic [39:0] total_bytes;
    logic        table_overflow;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] etype;
    logic [31:0] frames;
    logic [39:0] bytes;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_HIT_FRM,
    ST_HIT_BYT,
    ST_NEW,
    ST_GRP,
    ST_IP,
    ST_ALL,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT
  } state_t;

endpackage

FILE: src/ets_ram.sv
module ets_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/ets_sat_add.sv
module ets_sat_add (
  input  logic [39:0] a,
  input  logic [10:0] b,
  input  logic        wide,
  output logic [39:0] sum
);

  localparam logic [40:0] LIM40 = {1'b0, {40{1'b1}}};
  localparam logic [40:0] LIM32 = {9'b0, {32{1'b1}}};

  logic [40:0] raw;
  logic [40:0] lim;

  always_comb begin
    raw = {1'b0, a} + {30'b0, b};
    lim = wide ? LIM40 : LIM32;
    sum = (raw > lim) ? lim[39:0] : raw[39:0];
  end

endmodule

FILE: src/ethernet_frame_type_statistics.sv
// Counts received Ethernet frames per ethertype in a table of TABLE_DEPTH entries held in
// a single-port-read RAM, plus saturating global counters. A frame item keeps the input
// stalled while its ethertype is searched for, on a match and on a miss: each used entry
// costs one RAM read and one compare, and the entry and global counters then pass one at
// a time through one shared saturating adder. A report item also keeps the input stalled:
// each result is found by a full scan of the table for the next larger ethertype. The
// final result of a report sits in the output register while the next item is taken
// in.
module ethernet_frame_type_statistics #(
  parameter int TABLE_DEPTH = ets_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ets_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output ets_pkg::out_item_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [47:0]       cfg_data
);

  import ets_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t          state_r, state_nxt;
  logic [47:0]     mac_r, mac_nxt;
  logic [15:0]     type_r, type_nxt;
  logic [10:0]     len_r, len_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] emitted_r, emitted_nxt;
  logic [31:0]     frames_r, frames_nxt;
  logic [31:0]     forme_r, forme_nxt;
  logic [31:0]     mcast_r, mcast_nxt;
  logic [39:0]     ipv4_r, ipv4_nxt;
  logic [39:0]     ipv6_r, ipv6_nxt;
  logic [39:0]     total_r, total_nxt;
  logic            ovf_r, ovf_nxt;
  logic [47:0]     own_mac_r, own_mac_nxt;
  logic [15:0]     prev_r, prev_nxt;
  logic            first_r, first_nxt;
  logic            found_r, found_nxt;
  entry_t          best_r, best_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  logic            ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t          ram_wdata, ram_rdata;
  logic [39:0]     add_a, add_sum;
  logic [10:0]     add_b;
  logic            add_wide;

  logic            in_acc;
  logic            out_free;
  logic            is_last;

  ets_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ets_sat_add u_add (
    .a    (add_a),
    .b    (add_b),
    .wide (add_wide),
    .sum  (add_sum)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign is_last   = (used_r == '0) || (CNT_W'(emitted_r + 1'b1) == used_r);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_item.mode) begin
            state_nxt = ST_FIND_RD;
          end else if (used_r == '0) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_FIND_RD:  state_nxt = (idx_r == used_r) ? ST_NEW : ST_FIND_CMP;
      ST_FIND_CMP: state_nxt = (ram_rdata.etype == type_r) ? ST_HIT_FRM : ST_FIND_RD;
      ST_HIT_FRM:  state_nxt = ST_HIT_BYT;
      ST_HIT_BYT:  state_nxt = ST_GRP;
      ST_NEW:      state_nxt = ST_GRP;
      ST_GRP:      state_nxt = ST_IP;
      ST_IP:       state_nxt = ST_ALL;
      ST_ALL:      state_nxt = ST_IDLE;
      ST_SCAN_RD:  state_nxt = (idx_r == used_r) ? ST_EMIT : ST_SCAN_CMP;
      ST_SCAN_CMP: state_nxt = ST_SCAN_RD;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = is_last ? ST_IDLE : ST_SCAN_RD;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r[IDX_W-1:0];
    ram_wdata = {type_r, frames_r, add_sum};
    ram_re    = 1'b0;
    ram_raddr = idx_r[IDX_W-1:0];
    add_a     = '0;
    add_b     = len_r;
    add_wide  = 1'b1;
    case (state_r)
      ST_FIND_RD, ST_SCAN_RD: begin
        ram_re = (idx_r != used_r);
      end
      ST_HIT_FRM: begin
        add_a    = {8'b0, ram_rdata.frames};
        add_b    = 11'd1;
        add_wide = 1'b0;
      end
      ST_HIT_BYT: begin
        add_a  = ram_rdata.bytes;
        ram_we = 1'b1;
      end
      ST_NEW: begin
        ram_we    = (used_r < CNT_W'(TABLE_DEPTH));
        ram_waddr = used_r[IDX_W-1:0];
        ram_wdata = {type_r, 32'd1, 29'b0, len_r};
      end
      ST_GRP: begin
        add_a    = mac_r[40] ? {8'b0, mcast_r} : {8'b0, forme_r};
        add_b    = 11'd1;
        add_wide = 1'b0;
      end
      ST_IP: begin
        add_a = (type_r == TYPE_IPV4) ? ipv4_r : ipv6_r;
      end
      ST_ALL: begin
        add_a = total_r;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  always_comb begin
    mac_nxt       = mac_r;
    type_nxt      = type_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    emitted_nxt   = emitted_r;
    frames_nxt    = frames_r;
    forme_nxt     = forme_r;
    mcast_nxt     = mcast_r;
    ipv4_nxt      = ipv4_r;
    ipv6_nxt      = ipv6_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    own_mac_nxt   = cfg_valid ? cfg_data : own_mac_r;
    prev_nxt      = prev_r;
    first_nxt     = first_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mac_nxt     = in_item.dest_mac;
          type_nxt    = in_item.ethertype;
          len_nxt     = (in_item.frame_length > MAX_FRAME) ? MAX_FRAME : in_item.frame_length;
          idx_nxt     = '0;
          emitted_nxt = '0;
          first_nxt   = 1'b1;
          found_nxt   = 1'b0;
        end
      end
      ST_FIND_CMP: begin
        if (ram_rdata.etype != type_r) begin
          idx_nxt = CNT_W'(idx_r + 1'b1);
        end
      end
      ST_HIT_FRM: begin
        frames_nxt = add_sum[31:0];
      end
      ST_NEW: begin
        if (used_r < CNT_W'(TABLE_DEPTH)) begin
          used_nxt = CNT_W'(used_r + 1'b1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      ST_GRP: begin
        if (mac_r[40]) begin
          mcast_nxt = add_sum[31:0];
        end else if (mac_r == own_mac_r) begin
          forme_nxt = add_sum[31:0];
        end
      end
      ST_IP: begin
        if (type_r == TYPE_IPV4) begin
          ipv4_nxt = add_sum;
        end else if (type_r == TYPE_IPV6) begin
          ipv6_nxt = add_sum;
        end
      end
      ST_ALL: begin
        total_nxt = add_sum;
      end
      ST_SCAN_CMP: begin
        if ((first_r || ram_rdata.etype > prev_r) &&
            (!found_r || ram_rdata.etype < best_r.etype)) begin
          best_nxt  = ram_rdata;
          found_nxt = 1'b1;
        end
        idx_nxt = CNT_W'(idx_r + 1'b1);
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt                 = 1'b1;
          out_item_nxt.entry_valid      = found_r;
          out_item_nxt.entry_type       = found_r ? best_r.etype : '0;
          out_item_nxt.entry_frames     = found_r ? best_r.frames : '0;
          out_item_nxt.entry_bytes      = found_r ? best_r.bytes : '0;
          out_item_nxt.for_me_frames    = forme_r;
          out_item_nxt.multicast_frames = mcast_r;
          out_item_nxt.ipv4_bytes       = ipv4_r;
          out_item_nxt.ipv6_bytes       = ipv6_r;
          out_item_nxt.total_bytes      = total_r;
          out_item_nxt.table_overflow   = ovf_r;
          out_item_nxt.last             = is_last;
          emitted_nxt = CNT_W'(emitted_r + 1'b1);
          prev_nxt    = best_r.etype;
          first_nxt   = 1'b0;
          found_nxt   = 1'b0;
          idx_nxt     = '0;
        end
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      forme_r     <= '0;
      mcast_r     <= '0;
      ipv4_r      <= '0;
      ipv6_r      <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      own_mac_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      forme_r     <= forme_nxt;
      mcast_r     <= mcast_nxt;
      ipv4_r      <= ipv4_nxt;
      ipv6_r      <= ipv6_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      own_mac_r   <= own_mac_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mac_r      <= mac_nxt;
    type_r     <= type_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    emitted_r  <= emitted_nxt;
    frames_r   <= frames_nxt;
    prev_r     <= prev_nxt;
    first_r    <= first_nxt;
    found_r    <= found_nxt;
    best_r     <= best_nxt;
    out_item_r <= out_item_nxt;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(TABLE_DEPTH))
    else $error("table fill count exceeds the table depth");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared without reset");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> (used_r == CNT_W'(TABLE_DEPTH)))
    else $error("overflow flagged while the table had room");

  a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && used_r != '0) |-> found_r)
    else $error("report item emitted without a selected table entry");

endmodule

FILE: tb/ethernet_frame_type_statistics_tb.sv
`timescale 1ns / 1ps

module ethernet_frame_type_statistics_tb;
  import ets_pkg::*;

  localparam int TABLE_SLOTS = TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 80;
  localparam logic [47:0] GROUP_BIT = 48'h0100_0000_0000;
  localparam logic [7:0][15:0] COMMON_TYPES = {
    TYPE_IPV4, TYPE_IPV6, 16'h0806, 16'h8100, 16'h88CC, 16'h0000, 16'hFFFF, 16'h05DC
  };

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [47:0] cfg_data;

  logic [15:0] held_type [0:TABLE_SLOTS-1];
  logic [31:0] held_frames [0:TABLE_SLOTS-1];
  logic [39:0] held_bytes [0:TABLE_SLOTS-1];
  int          types_held;
  logic [31:0] for_me_cnt;
  logic [31:0] multicast_cnt;
  logic [39:0] ipv4_sum;
  logic [39:0] ipv6_sum;
  logic [39:0] all_sum;
  logic        type_dropped;
  logic [47:0] station_mac;

  out_item_t   rows_due [$];
  stim_row_t   script [0:12];
  int          mismatches;
  int          cycles;
  bit          steady;

  ethernet_frame_type_statistics dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] bump32(logic [31:0] a);
    return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
  endfunction

  function automatic logic [39:0] add40(logic [39:0] a, logic [39:0] b);
    logic [40:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[40] ? 40'hFF_FFFF_FFFF : s[39:0];
  endfunction

  function automatic out_item_t stats_row(logic valid, logic [15:0] et, logic [31:0] frames,
                                          logic [39:0] bytes, logic is_last);
    out_item_t r;
    r.entry_valid = valid;
    r.entry_type = et;
    r.entry_frames = frames;
    r.entry_bytes = bytes;
    r.for_me_frames = for_me_cnt;
    r.multicast_frames = multicast_cnt;
    r.ipv4_bytes = ipv4_sum;
    r.ipv6_bytes = ipv6_sum;
    r.total_bytes = all_sum;
    r.table_overflow = type_dropped;
    r.last = is_last;
    return r;
  endfunction

  task automatic count_frame(input in_item_t it);
    logic [39:0] len;
    int hit;
    len = (it.frame_length > MAX_FRAME) ? 40'(MAX_FRAME) : 40'(it.frame_length);
    hit = -1;
    for (int i = 0; i < types_held; i++) begin
      if (hit < 0 && held_type[i] == it.ethertype) hit = i;
    end
    if (hit >= 0) begin
      held_frames[hit] = bump32(held_frames[hit]);
      held_bytes[hit] = add40(held_bytes[hit], len);
    end else if (types_held < TABLE_SLOTS) begin
      held_type[types_held] = it.ethertype;
      held_frames[types_held] = 32'd1;
      held_bytes[types_held] = len;
      types_held++;
    end else begin
      type_dropped = 1'b1;
    end
    if (it.dest_mac[40]) multicast_cnt = bump32(multicast_cnt);
    else if (it.dest_mac == station_mac) for_me_cnt = bump32(for_me_cnt);
    if (it.ethertype == TYPE_IPV4) ipv4_sum = add40(ipv4_sum, len);
    else if (it.ethertype == TYPE_IPV6) ipv6_sum = add40(ipv6_sum, len);
    all_sum = add40(all_sum, len);
  endtask

  task automatic list_table();
    int order [0:TABLE_SLOTS-1];
    int j;
    int k;
    if (types_held == 0) begin
      rows_due.push_back(stats_row(1'b0, 16'h0, 32'h0, 40'h0, 1'b1));
    end else begin
      for (int i = 0; i < types_held; i++) begin
        j = i;
        while (j > 0 && held_type[order[j-1]] > held_type[i]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
      end
      for (int i = 0; i < types_held; i++) begin
        k = order[i];
        rows_due.push_back(stats_row(1'b1, held_type[k], held_frames[k], held_bytes[k],
                                     i == types_held - 1));
      end
    end
  endtask

  function automatic stim_row_t frame_row(logic [47:0] mac, logic [15:0] et, logic [10:0] len);
    stim_row_t r;
    r = '0;
    r.item.dest_mac = mac;
    r.item.ethertype = et;
    r.item.frame_length = len;
    return r;
  endfunction

  function automatic in_item_t random_item(int report_pct, int fresh_pct);
    in_item_t it;
    logic [63:0] wide;
    int pick;
    wide = {$urandom(), $urandom()};
    it.mode = ($urandom_range(0, 99) < report_pct);
    pick = $urandom_range(0, 99);
    if (pick < 25) it.dest_mac = station_mac;
    else if (pick < 35) it.dest_mac = '1;
    else if (pick < 45) it.dest_mac = station_mac ^ GROUP_BIT;
    else it.dest_mac = wide[47:0];
    if ($urandom_range(0, 99) < fresh_pct) it.ethertype = wide[63:48];
    else it.ethertype = COMMON_TYPES[$urandom_range(0, 7)];
    pick = $urandom_range(0, 99);
    if (pick < 10) it.frame_length = MAX_FRAME;
    else if (pick < 20) it.frame_length = 11'($urandom_range(1515, 2047));
    else if (pick < 30) it.frame_length = 11'($urandom_range(0, 63));
    else it.frame_length = 11'($urandom_range(64, 1514));
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    while (!steady && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    if (!it.mode) count_frame(it);
    else if (typed) rows_due.push_back(want);
    else list_table();
  endtask

  task automatic set_station(input logic [47:0] mac);
    in_valid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mac;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    station_mac = mac;
  endtask

  function automatic int field_diff(string name, logic [47:0] got, logic [47:0] want);
    if (got === want) return 0;
    if (mismatches < 10) $display("%s: expected %h, got %h", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 14);
  end

  always @(posedge clk) begin : check_rows
    out_item_t want;
    int bad;
    if (rst_n && out_valid && !out_stall) begin
      if (rows_due.size() == 0) begin
        if (mismatches < 10) $display("report row with none expected: %h", out_item);
        mismatches++;
      end else begin
        want = rows_due.pop_front();
        bad = field_diff("entry_valid", 48'(out_item.entry_valid), 48'(want.entry_valid))
            + field_diff("entry_type", 48'(out_item.entry_type), 48'(want.entry_type))
            + field_diff("entry_frames", 48'(out_item.entry_frames),
                         48'(want.entry_frames))
            + field_diff("entry_bytes", 48'(out_item.entry_bytes), 48'(want.entry_bytes))
            + field_diff("for_me_frames", 48'(out_item.for_me_frames),
                         48'(want.for_me_frames))
            + field_diff("multicast_frames", 48'(out_item.multicast_frames),
                         48'(want.multicast_frames))
            + field_diff("ipv4_bytes", 48'(out_item.ipv4_bytes), 48'(want.ipv4_bytes))
            + field_diff("ipv6_bytes", 48'(out_item.ipv6_bytes), 48'(want.ipv6_bytes))
            + field_diff("total_bytes", 48'(out_item.total_bytes), 48'(want.total_bytes))
            + field_diff("table_overflow", 48'(out_item.table_overflow),
                         48'(want.table_overflow))
            + field_diff("last", 48'(out_item.last), 48'(want.last));
        if (bad != 0) mismatches++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ethernet_frame_type_statistics regression: fail");
      $finish;
    end
  end

  initial begin
    in_item_t burst;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    steady = 1'b0;
    mismatches = 0;
    cycles = 0;
    types_held = 0;
    for_me_cnt = '0;
    multicast_cnt = '0;
    ipv4_sum = '0;
    ipv6_sum = '0;
    all_sum = '0;
    type_dropped = 1'b0;
    station_mac = '0;

    // An empty table reports one row without an entry.
    script[0] = '0;
    script[0].item.mode = 1'b1;
    script[0].typed = 1'b1;
    script[0].want.last = 1'b1;
    script[1] = frame_row(48'hFFFF_FFFF_FFFF, 16'hFFFF, 11'd2047);
    // The overlong broadcast frame counts as a full-size multicast frame.
    script[2] = '0;
    script[2].item.mode = 1'b1;
    script[2].typed = 1'b1;
    script[2].want.entry_valid = 1'b1;
    script[2].want.entry_type = 16'hFFFF;
    script[2].want.entry_frames = 32'd1;
    script[2].want.entry_bytes = 40'd1514;
    script[2].want.multicast_frames = 32'd1;
    script[2].want.total_bytes = 40'd1514;
    script[2].want.last = 1'b1;
    script[3] = frame_row(48'h0, 16'h0000, 11'd0);
    script[4] = frame_row(48'h0, TYPE_IPV4, MAX_FRAME);
    script[5] = frame_row(48'h0000_0000_0001, TYPE_IPV6, 11'd1515);
    script[6] = frame_row(48'h0100_5E00_0001, TYPE_IPV4, 11'd64);
    script[7] = frame_row(48'hFEFF_FFFF_FFFF, 16'h0806, 11'd60);
    script[8] = frame_row(GROUP_BIT, 16'hFFFF, 11'd1);
    script[9] = frame_row(48'h0, 16'h0000, 11'd2047);
    script[10] = '0;
    script[10].item = {1'b1, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 11'h7FF};
    script[11] = frame_row(48'h0, 16'h8100, 11'd1024);
    script[12] = '0;
    script[12].item.mode = 1'b1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    set_station(48'h0);
    foreach (script[i]) send_item(script[i].item, script[i].typed, script[i].want);

    set_station(48'hFFFF_FFFF_FFFF);
    repeat (30) send_item(random_item(20, 5), 1'b0, '0);

    set_station(48'({$urandom(), $urandom()}) & ~GROUP_BIT);
    steady = 1'b1;
    repeat (30) send_item(random_item(20, 10), 1'b0, '0);

    set_station(48'({$urandom(), $urandom()}));
    steady = 1'b0;
    // Twelve new ethertypes fill the table and force the overflow flag.
    for (int k = 0; k < 12; k++) begin
      burst = random_item(0, 0);
      burst.ethertype = {4'hA, 4'(k), 8'($urandom())};
      send_item(burst, 1'b0, '0);
    end
    repeat (25) send_item(random_item(25, 30), 1'b0, '0);
    burst = random_item(100, 0);
    send_item(burst, 1'b0, '0);
    in_valid <= 1'b0;

    while (rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (rows_due.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("ethernet_frame_type_statistics regression: pass");
    end else begin
      $display("ethernet_frame_type_statistics regression: fail");
    end
    $finish;
  end

endmodule
